[design/mps_pkg.sv]
// Package: sizes, level queue command and status types for the scheduler.
`timescale 1ns / 1ps
package mps_pkg;
  localparam int MAX_PROCS  = 32;
  localparam int NUM_LEVELS = 4;
  localparam int ID_W       = 5;
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int WAIT_W     = 8;
  localparam logic [WAIT_W-1:0] WAIT_MAX    = 8'hFF;
  localparam logic [7:0]        AGING_RESET = 8'd5;

  typedef enum logic [1:0] {
    LQ_NOP  = 2'd0,
    LQ_PUSH = 2'd1,
    LQ_POP  = 2'd2,
    LQ_ROT  = 2'd3
  } lq_op_t;

  typedef struct packed {
    lq_op_t          op;
    logic [ID_W-1:0] id;
  } lq_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  head;
    logic [CNT_W-1:0] count;
  } lq_stat_t;
endpackage

[design/multilevel_priority_scheduler_aging_unit.sv]
// Top level: level queues, per-id bookkeeping and the tick sequencer.
//   channel | signals                                   | dir
//   in      | in_valid in_ready op process_id level run_length | in
//   out     | out_valid out_ready idle served_id first_run finished | out
//   cfg     | cfg_valid cfg_ready cfg_data              | in
// An arrival word is handled while idle. A tick is accepted, served, then
// each level is aged and each of levels 1..3 is scanned for promotion: load
// the count, one entry per cycle through the single wait-counter port, then
// step on. Reset empties queues, clears started flags, loads AGING_RESET threshold.
// The serve cycle stalls while a previous result word is still waiting.
`timescale 1ns / 1ps
module multilevel_priority_scheduler_aging_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [4:0]               process_id,
  input  logic [1:0]               level,
  input  logic [7:0]               run_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     idle,
  output logic [4:0]               served_id,
  output logic                     first_run,
  output logic                     finished,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_data
);
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SERVE = 4'b0010,
    ST_AGE   = 4'b0100,
    ST_PROMO = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [mps_pkg::LVL_W-1:0] lv, lv_next;
  logic [mps_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      fresh, fresh_next;
  logic [7:0]                threshold;

  logic [7:0]                rem     [mps_pkg::MAX_PROCS];
  logic [mps_pkg::WAIT_W-1:0] wait_q [mps_pkg::MAX_PROCS];
  logic                      started [mps_pkg::MAX_PROCS];

  mps_pkg::lq_cmd_t  cmd  [mps_pkg::NUM_LEVELS];
  mps_pkg::lq_stat_t stat [mps_pkg::NUM_LEVELS];

  logic                      rem_we, wait_we, start_we, start_val;
  logic [mps_pkg::ID_W-1:0]  rem_id, wait_id, start_id;
  logic [7:0]                rem_val;
  logic [mps_pkg::WAIT_W-1:0] wait_val;

  logic                      res_load, res_idle, res_first, res_fin;
  logic [mps_pkg::ID_W-1:0]  res_id;

  logic [mps_pkg::LVL_W-1:0] sel, lv_up;
  logic                      any;
  logic [mps_pkg::ID_W-1:0]  cur_head, sel_head;
  logic [mps_pkg::WAIT_W-1:0] wait_cur;
  logic                      out_free;

  for (genvar l = 0; l < mps_pkg::NUM_LEVELS; l++) begin : g_lvl
    mps_level u_level (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd[l]),
      .stat (stat[l])
    );
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign lv_up     = lv - 1'b1;
  assign cur_head  = stat[lv].head;
  assign wait_cur  = wait_q[cur_head];
  assign sel_head  = stat[sel].head;

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int l = mps_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
      if (stat[l].count != '0) begin
        sel = mps_pkg::LVL_W'(l);
        any = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    lv_next    = lv;
    cnt_next   = cnt;
    fresh_next = fresh;
    for (int l = 0; l < mps_pkg::NUM_LEVELS; l++) begin
      cmd[l].op = mps_pkg::LQ_NOP;
      cmd[l].id = cur_head;
    end
    rem_we    = 1'b0;
    rem_id    = process_id;
    rem_val   = run_length;
    wait_we   = 1'b0;
    wait_id   = cur_head;
    wait_val  = '0;
    start_we  = 1'b0;
    start_id  = process_id;
    start_val = 1'b0;
    res_load  = 1'b0;
    res_idle  = 1'b1;
    res_id    = '0;
    res_first = 1'b0;
    res_fin   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op) begin
            state_next = ST_SERVE;
          end else if (stat[level].count != mps_pkg::CNT_W'(mps_pkg::MAX_PROCS)) begin
            cmd[level].op = mps_pkg::LQ_PUSH;
            cmd[level].id = process_id;
            rem_we        = 1'b1;
            wait_we       = 1'b1;
            wait_id       = process_id;
            start_we      = 1'b1;
          end
        end
      end
      ST_SERVE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_AGE;
          lv_next    = '0;
          fresh_next = 1'b1;
          if (any) begin
            res_idle  = 1'b0;
            res_id    = sel_head;
            res_first = !started[sel_head];
            start_we  = 1'b1;
            start_id  = sel_head;
            start_val = 1'b1;
            rem_we    = 1'b1;
            rem_id    = sel_head;
            if (rem[sel_head] <= 8'd1) begin
              rem_val     = '0;
              res_fin     = 1'b1;
              cmd[sel].op = mps_pkg::LQ_POP;
            end else begin
              rem_val     = rem[sel_head] - 1'b1;
              cmd[sel].op = mps_pkg::LQ_ROT;
            end
          end
        end
      end
      ST_AGE: begin
        if (fresh) begin
          cnt_next   = stat[lv].count;
          fresh_next = 1'b0;
        end else if (cnt == '0) begin
          fresh_next = 1'b1;
          if (lv == mps_pkg::LVL_W'(mps_pkg::NUM_LEVELS - 1)) begin
            state_next = ST_PROMO;
            lv_next    = mps_pkg::LVL_W'(1);
          end else begin
            lv_next = lv + 1'b1;
          end
        end else begin
          cmd[lv].op = mps_pkg::LQ_ROT;
          wait_we    = 1'b1;
          wait_val   = (wait_cur == mps_pkg::WAIT_MAX) ? wait_cur : wait_cur + 1'b1;
          cnt_next   = cnt - 1'b1;
        end
      end
      ST_PROMO: begin
        if (fresh) begin
          cnt_next   = stat[lv].count;
          fresh_next = 1'b0;
        end else if (cnt == '0) begin
          fresh_next = 1'b1;
          if (lv == mps_pkg::LVL_W'(mps_pkg::NUM_LEVELS - 1)) begin
            state_next = ST_IDLE;
          end else begin
            lv_next = lv + 1'b1;
          end
        end else begin
          cnt_next = cnt - 1'b1;
          if ((wait_cur >= threshold) &&
              (stat[lv_up].count != mps_pkg::CNT_W'(mps_pkg::MAX_PROCS))) begin
            cmd[lv].op    = mps_pkg::LQ_POP;
            cmd[lv_up].op = mps_pkg::LQ_PUSH;
            wait_we       = 1'b1;
            wait_val      = '0;
          end else begin
            cmd[lv].op = mps_pkg::LQ_ROT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lv        <= '0;
      cnt       <= '0;
      fresh     <= 1'b0;
      threshold <= mps_pkg::AGING_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < mps_pkg::MAX_PROCS; i++) begin
        started[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      lv    <= lv_next;
      cnt   <= cnt_next;
      fresh <= fresh_next;
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start_we) begin
        started[start_id] <= start_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem[rem_id] <= rem_val;
    end
    if (wait_we) begin
      wait_q[wait_id] <= wait_val;
    end
    if (res_load) begin
      idle      <= res_idle;
      served_id <= res_id;
      first_run <= res_first;
      finished  <= res_fin;
    end
  end
endmodule

[design/mps_cell.sv]
// One queue slot: loads a new id or takes its right neighbour's id.
`timescale 1ns / 1ps
module mps_cell (
  input  logic                     clk,
  input  logic                     shift,
  input  logic                     load,
  input  logic [mps_pkg::ID_W-1:0] right_in,
  input  logic [mps_pkg::ID_W-1:0] load_in,
  output logic [mps_pkg::ID_W-1:0] q
);
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_in;
    end else if (shift) begin
      q <= right_in;
    end
  end
endmodule

[design/mps_level.sv]
// One priority level: a row of cells, head at cell 0, with a fill count.
`timescale 1ns / 1ps
module mps_level (
  input  logic              clk,
  input  logic              rst,
  input  mps_pkg::lq_cmd_t  cmd,
  output mps_pkg::lq_stat_t stat
);
  logic [mps_pkg::ID_W-1:0]  q [mps_pkg::MAX_PROCS];
  logic [mps_pkg::CNT_W-1:0] count;
  logic                      shift;
  logic [mps_pkg::ID_W-1:0]  load_in;

  assign shift   = (cmd.op == mps_pkg::LQ_POP) || (cmd.op == mps_pkg::LQ_ROT);
  assign load_in = (cmd.op == mps_pkg::LQ_PUSH) ? cmd.id : q[0];

  for (genvar i = 0; i < mps_pkg::MAX_PROCS; i++) begin : g_cell
    logic load;
    logic [mps_pkg::ID_W-1:0] right_in;
    assign load = ((cmd.op == mps_pkg::LQ_PUSH) && (count == mps_pkg::CNT_W'(i))) ||
                  ((cmd.op == mps_pkg::LQ_ROT) && (count == mps_pkg::CNT_W'(i + 1)));
    if (i == mps_pkg::MAX_PROCS - 1) begin : g_last
      assign right_in = q[i];
    end else begin : g_mid
      assign right_in = q[i+1];
    end
    mps_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .load     (load),
      .right_in (right_in),
      .load_in  (load_in),
      .q        (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        mps_pkg::LQ_PUSH: count <= count + 1'b1;
        mps_pkg::LQ_POP:  count <= count - 1'b1;
        default:          count <= count;
      endcase
    end
  end

  assign stat.head  = q[0];
  assign stat.count = count;
endmodule

[design/mps_checker.sv]
// Port-level checks for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module mps_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       op,
  input logic       out_valid,
  input logic       out_ready,
  input logic       idle,
  input logic [4:0] served_id,
  input logic       first_run,
  input logic       finished
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(served_id) && $stable(idle))
    else $error("result word changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> served_id == 5'd0 && !first_run && !finished)
    else $error("idle result carries data");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op |=> !in_ready)
    else $error("tick word did not hold input");

  a_reset_ready: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready && !out_valid)
    else $error("not ready after reset");
endmodule

bind multilevel_priority_scheduler_aging_unit mps_checker u_mps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .op        (op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .idle      (idle),
  .served_id (served_id),
  .first_run (first_run),
  .finished  (finished)
);

[test/tb_top.sv]
// Testbench for the multilevel priority scheduler with aging: directed and random arrivals and ticks.
`timescale 1ns / 1ps
module tb_top;
  typedef enum logic {OP_ARRIVE = 1'b0, OP_TICK = 1'b1} sched_op_t;

  typedef struct packed {
    logic       op;
    logic [4:0] pid;
    logic [1:0] lvl;
    logic [7:0] len;
  } sched_word_t;

  typedef struct packed {
    logic       idle;
    logic [4:0] sid;
    logic       first;
    logic       fin;
  } serve_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic op = 1'b0;
  logic [4:0] process_id = '0;
  logic [1:0] level = '0;
  logic [7:0] run_length = '0;
  logic out_valid, out_ready = 1'b0;
  logic idle, first_run, finished;
  logic [4:0] served_id;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [7:0] cfg_data = '0;

  multilevel_priority_scheduler_aging_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .process_id(process_id),
    .level(level), .run_length(run_length),
    .out_valid(out_valid), .out_ready(out_ready), .idle(idle), .served_id(served_id),
    .first_run(first_run), .finished(finished),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // scheduler shadow state
  logic [4:0] ring [mps_pkg::NUM_LEVELS][mps_pkg::MAX_PROCS];
  int         rhead [mps_pkg::NUM_LEVELS];
  int         rcount [mps_pkg::NUM_LEVELS];
  logic [7:0] remain [mps_pkg::MAX_PROCS];
  logic [7:0] waited [mps_pkg::MAX_PROCS];
  logic       started [mps_pkg::MAX_PROCS];
  logic [7:0] threshold;

  sched_word_t pending_words[$];
  serve_word_t expected_serves[$];
  int errors = 0;
  int hold_off = 0;

  function automatic bit ring_push(int lv, logic [4:0] id);
    if (rcount[lv] >= mps_pkg::MAX_PROCS) return 0;
    ring[lv][(rhead[lv] + rcount[lv]) % mps_pkg::MAX_PROCS] = id;
    rcount[lv]++;
    return 1;
  endfunction

  function automatic logic [4:0] ring_pop(int lv);
    logic [4:0] id;
    id = ring[lv][rhead[lv]];
    rhead[lv] = (rhead[lv] + 1) % mps_pkg::MAX_PROCS;
    rcount[lv]--;
    return id;
  endfunction

  task automatic schedule_word(sched_word_t w);
    serve_word_t r;
    logic [4:0] id;
    int n;
    bit done;
    if (w.op == OP_ARRIVE) begin
      if (ring_push(int'(w.lvl), w.pid)) begin
        remain[w.pid] = w.len;
        waited[w.pid] = 0;
        started[w.pid] = 0;
      end
      return;
    end
    r = '{idle: 1'b1, sid: '0, first: 1'b0, fin: 1'b0};
    done = 0;
    for (int lv = 0; lv < mps_pkg::NUM_LEVELS; lv++) begin
      if (!done && rcount[lv] != 0) begin
        id = ring_pop(lv);
        done = 1;
        r.idle = 0;
        r.sid = id;
        r.first = !started[id];
        started[id] = 1;
        if (remain[id] <= 1) begin
          remain[id] = 0;
          r.fin = 1;
        end else begin
          remain[id]--;
          void'(ring_push(lv, id));
        end
      end
    end
    for (int lv = 0; lv < mps_pkg::NUM_LEVELS; lv++)
      for (int s = 0; s < rcount[lv]; s++) begin
        id = ring[lv][(rhead[lv] + s) % mps_pkg::MAX_PROCS];
        if (waited[id] != mps_pkg::WAIT_MAX) waited[id]++;
      end
    for (int lv = 1; lv < mps_pkg::NUM_LEVELS; lv++) begin
      n = rcount[lv];
      while (n != 0) begin
        id = ring_pop(lv);
        n--;
        if (waited[id] >= threshold && ring_push(lv - 1, id)) waited[id] = 0;
        else void'(ring_push(lv, id));
      end
    end
    expected_serves.push_back(r);
  endtask

  // driver
  int in_gap = 0;
  sched_word_t drv_word;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        schedule_word(sched_word_t'({op, process_id, level, run_length}));
        in_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end else if (!in_valid && in_gap > 0) begin
        in_gap--;
      end
      if (!in_valid || in_ready) begin
        if (in_gap == 0 && pending_words.size() != 0) begin
          drv_word = pending_words.pop_front();
          {op, process_id, level, run_length} <= drv_word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        serve_word_t got, want;
        got = '{idle, served_id, first_run, finished};
        if (expected_serves.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_serves.pop_front();
          if (got.idle !== want.idle)
            $display("%0t: idle exp %0d got %0d", $time, want.idle, got.idle);
          if (got.sid !== want.sid)
            $display("%0t: served_id exp %0d got %0d", $time, want.sid, got.sid);
          if (got.first !== want.first)
            $display("%0t: first_run exp %0d got %0d", $time, want.first, got.first);
          if (got.fin !== want.fin)
            $display("%0t: finished exp %0d got %0d", $time, want.fin, got.fin);
          if (got !== want) errors++;
        end
        out_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  function automatic sched_word_t arrival(logic [4:0] pid, logic [1:0] lvl, logic [7:0] len);
    return '{op: OP_ARRIVE, pid: pid, lvl: lvl, len: len};
  endfunction

  function automatic sched_word_t tick();
    return '{op: OP_TICK, pid: 5'($urandom), lvl: 2'($urandom), len: 8'($urandom)};
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_serves.size() != 0 ||
           !in_ready)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    threshold = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 45)
        pending_words.push_back(arrival(5'($urandom), 2'($urandom),
          ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6))));
      else pending_words.push_back(tick());
    end
  endtask

  initial begin
    for (int l = 0; l < mps_pkg::NUM_LEVELS; l++) begin
      rhead[l] = 0;
      rcount[l] = 0;
    end
    for (int p = 0; p < mps_pkg::MAX_PROCS; p++) started[p] = 0;
    threshold = mps_pkg::AGING_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, extremes, zero length, duplicate id, all levels
    pending_words.push_back(tick());
    pending_words.push_back(arrival(5'd0, 2'd3, 8'd255));
    pending_words.push_back(arrival(5'd31, 2'd0, 8'd1));
    pending_words.push_back(arrival(5'd10, 2'd1, 8'd0));
    pending_words.push_back(arrival(5'd21, 2'd2, 8'd3));
    pending_words.push_back(arrival(5'd21, 2'd2, 8'd2));
    for (int i = 0; i < 14; i++) pending_words.push_back(tick());
    drain();

    // fill level 3 past its depth while the receiver is held off
    hold_off = 600;
    for (int i = 0; i < 34; i++) pending_words.push_back(arrival(5'(i), 2'd3, 8'd2));
    for (int i = 0; i < 40; i++) pending_words.push_back(tick());
    drain();

    write_threshold(8'd0);
    random_phase(250);
    drain();
    write_threshold(8'd255);
    random_phase(250);
    drain();
    write_threshold(8'd1);
    random_phase(400);
    drain();
    write_threshold(8'd5);
    random_phase(450);
    drain();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[files.f]
design/mps_pkg.sv
design/mps_cell.sv
design/mps_level.sv
design/multilevel_priority_scheduler_aging_unit.sv
design/mps_checker.sv
test/tb_top.sv
